// File: rtl/core/lcfb_pkg.sv
// Package with the item types, frame constants and helper functions of the frame builder.
`timescale 1ns / 1ps

package lcfb_pkg;

    // Command actions.
    localparam logic [2:0] ACT_DEV_CTRL   = 3'd0;
    localparam logic [2:0] ACT_GRP_SINGLE = 3'd1;
    localparam logic [2:0] ACT_GRP_LIST   = 3'd2;
    localparam logic [2:0] ACT_GRP_SET    = 3'd3;
    localparam logic [2:0] ACT_SENSOR     = 3'd4;
    localparam logic [2:0] ACT_DEV_INFO   = 3'd5;

    // Fixed frame bytes.
    localparam logic [7:0] B_SOF       = 8'h2A;
    localparam logic [7:0] B_LEN_LONG  = 8'h27;
    localparam logic [7:0] B_LEN_SHORT = 8'h22;
    localparam logic [7:0] B_SYNC0     = 8'h41;
    localparam logic [7:0] B_SYNC1     = 8'h88;
    localparam logic [7:0] B_TYPE_CTRL = 8'h25;
    localparam logic [7:0] B_TYPE_INFO = 8'h20;
    localparam logic [7:0] B_CMD_CTRL0 = 8'hC1;
    localparam logic [7:0] B_CMD_CTRL1 = 8'h2B;
    localparam logic [7:0] B_CMD_GSET0 = 8'hE9;
    localparam logic [7:0] B_CMD_GSET1 = 8'h03;
    localparam logic [7:0] B_CMD_SENS0 = 8'h94;
    localparam logic [7:0] B_CMD_SENS1 = 8'h2A;
    localparam logic [7:0] B_GSET_SUB  = 8'h06;
    localparam logic [7:0] B_CLASS     = 8'h04;
    localparam logic [7:0] B_ONE       = 8'h01;
    localparam logic [7:0] B_BCAST     = 8'hFF;
    localparam logic [7:0] B_EOF       = 8'h23;

    // Frame lengths as last byte index.
    localparam logic [5:0] LAST_LONG  = 6'd42;
    localparam logic [5:0] LAST_SHORT = 6'd37;

    // Checksum contribution of the fixed bytes of each layout.
    localparam logic [7:0] SUM_DEV = 8'(int'(B_SYNC0) + int'(B_SYNC1) + int'(B_TYPE_CTRL)
        + int'(B_CMD_CTRL0) + int'(B_CMD_CTRL1) + int'(B_CLASS) + int'(B_ONE));
    localparam logic [7:0] SUM_INFO = 8'(int'(B_SYNC0) + int'(B_SYNC1) + int'(B_TYPE_INFO)
        + int'(B_CMD_CTRL0) + int'(B_CMD_CTRL1) + int'(B_CLASS) + int'(B_ONE));
    localparam logic [7:0] SUM_GRP = 8'(int'(B_SYNC0) + int'(B_SYNC1) + 4 * int'(B_BCAST)
        + int'(B_TYPE_CTRL) + int'(B_ONE) + int'(B_CMD_CTRL0) + int'(B_CMD_CTRL1)
        + int'(B_CLASS) + int'(B_ONE));
    localparam logic [7:0] SUM_GSET = 8'(int'(B_SYNC0) + int'(B_SYNC1) + int'(B_TYPE_CTRL)
        + int'(B_CMD_GSET0) + int'(B_CMD_GSET1) + int'(B_GSET_SUB) + int'(B_CLASS));
    localparam logic [7:0] SUM_SENS = 8'(int'(B_SYNC0) + int'(B_SYNC1) + int'(B_TYPE_INFO)
        + int'(B_CMD_SENS0) + int'(B_CMD_SENS1));

    // One command item.
    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] device_address;
        logic [4:0]  group_id;
        logic [15:0] group_mask;
        logic [7:0]  on_off;
        logic [15:0] dimmer;
    } t_lcfb_cmd;

    // One frame byte item.
    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
    } t_lcfb_result;

    // Actions 6 and 7 produce no frame.
    function automatic logic action_valid(input logic [2:0] act);
        return (act <= ACT_DEV_INFO);
    endfunction

    // Group mask carried by the group modes; an out-of-range id gives no bits.
    function automatic logic [15:0] group_bits(input t_lcfb_cmd cmd);
        logic [15:0] single;
        single = '0;
        if (cmd.group_id >= 5'd1 && cmd.group_id <= 5'd16) begin
            single = 16'd1 << (cmd.group_id - 5'd1);
        end
        return (cmd.action == ACT_GRP_LIST) ? cmd.group_mask : single;
    endfunction

    // Index of the closing byte for an action.
    function automatic logic [5:0] last_index(input logic [2:0] act);
        return (act == ACT_SENSOR) ? LAST_SHORT : LAST_LONG;
    endfunction

endpackage

// File: rtl/core/lcfb_byte_mux.sv
// Frame byte selector: picks the byte at a given index of the frame for a stored command.
`timescale 1ns / 1ps

module lcfb_byte_mux (
    input  lcfb_pkg::t_lcfb_cmd    i_cmd,
    input  logic [5:0]             i_idx,
    input  logic [7:0]             i_checksum,
    output lcfb_pkg::t_lcfb_result o_result
);

    logic [15:0] mask;
    logic        is_grp;
    logic        is_short_type;
    logic [5:0]  last_idx;
    logic [7:0]  body;

    // Layout flags for the stored action.
    always_comb begin
        mask          = lcfb_pkg::group_bits(i_cmd);
        is_grp        = (i_cmd.action == lcfb_pkg::ACT_GRP_SINGLE) ||
                        (i_cmd.action == lcfb_pkg::ACT_GRP_LIST);
        is_short_type = (i_cmd.action == lcfb_pkg::ACT_SENSOR) ||
                        (i_cmd.action == lcfb_pkg::ACT_DEV_INFO);
        last_idx      = lcfb_pkg::last_index(i_cmd.action);
    end

    // Body bytes by position; padding positions are zero.
    always_comb begin
        body = 8'h00;
        case (i_idx)
            6'd0: body = lcfb_pkg::B_SOF;
            6'd1: body = is_short_type ? lcfb_pkg::B_LEN_SHORT : lcfb_pkg::B_LEN_LONG;
            6'd2: body = lcfb_pkg::B_SYNC0;
            6'd3: body = lcfb_pkg::B_SYNC1;
            6'd18: body = is_grp ? lcfb_pkg::B_BCAST : i_cmd.device_address[7:0];
            6'd19: body = is_grp ? lcfb_pkg::B_BCAST : i_cmd.device_address[15:8];
            6'd20: body = is_grp ? lcfb_pkg::B_BCAST : i_cmd.device_address[23:16];
            6'd21: body = is_grp ? lcfb_pkg::B_BCAST : i_cmd.device_address[31:24];
            6'd28: body = is_short_type ? lcfb_pkg::B_TYPE_INFO : lcfb_pkg::B_TYPE_CTRL;
            6'd29: body = is_grp ? lcfb_pkg::B_ONE : 8'h00;
            6'd30: body = is_grp ? mask[7:0] : 8'h00;
            6'd31: body = is_grp ? mask[15:8] : 8'h00;
            6'd32: begin
                if (i_cmd.action == lcfb_pkg::ACT_GRP_SET) begin
                    body = lcfb_pkg::B_CMD_GSET0;
                end else if (i_cmd.action == lcfb_pkg::ACT_SENSOR) begin
                    body = lcfb_pkg::B_CMD_SENS0;
                end else begin
                    body = lcfb_pkg::B_CMD_CTRL0;
                end
            end
            6'd33: begin
                if (i_cmd.action == lcfb_pkg::ACT_GRP_SET) begin
                    body = lcfb_pkg::B_CMD_GSET1;
                end else if (i_cmd.action == lcfb_pkg::ACT_SENSOR) begin
                    body = lcfb_pkg::B_CMD_SENS1;
                end else begin
                    body = lcfb_pkg::B_CMD_CTRL1;
                end
            end
            6'd34: body = (i_cmd.action == lcfb_pkg::ACT_GRP_SET) ? lcfb_pkg::B_GSET_SUB : 8'h00;
            6'd36: body = lcfb_pkg::B_CLASS;
            6'd37: body = (i_cmd.action == lcfb_pkg::ACT_GRP_SET) ? mask[7:0] : lcfb_pkg::B_ONE;
            6'd38: body = (i_cmd.action == lcfb_pkg::ACT_GRP_SET) ? mask[15:8] : i_cmd.on_off;
            6'd39: body = (i_cmd.action == lcfb_pkg::ACT_GRP_SET) ? 8'h00 : i_cmd.dimmer[7:0];
            6'd40: body = (i_cmd.action == lcfb_pkg::ACT_GRP_SET) ? 8'h00 : i_cmd.dimmer[15:8];
            default: body = 8'h00;
        endcase
    end

    // The checksum and the closing byte sit at the tail, whatever the length.
    always_comb begin
        o_result.last_byte = (i_idx == last_idx);
        if (i_idx == last_idx) begin
            o_result.frame_byte = lcfb_pkg::B_EOF;
        end else if (i_idx == last_idx - 6'd1) begin
            o_result.frame_byte = i_checksum;
        end else begin
            o_result.frame_byte = body;
        end
    end

endmodule

// File: rtl/core/lighting_command_frame_builder.sv
// Top level of the lighting command frame builder: command capture, byte sequencing, output register.
// The first byte of a frame passes the index register, then the output register, to reach o_result.
// Throughput: one byte per cycle; a frame is 43 bytes long (38 for the sensor query), set by
// the byte counter. The next command is taken while the checksum byte is on o_result, so frames
// run back to back with no gap.
// Commands with action 6 or 7 are accepted and produce no bytes.
// Reset (synchronous, active low) clears the sequencer and the strobe; the receiver cannot stall.
`timescale 1ns / 1ps

module lighting_command_frame_builder (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    input  lcfb_pkg::t_lcfb_cmd    i_cmd,
    output logic                   busy,
    output logic                   o_strobe,
    output lcfb_pkg::t_lcfb_result o_result
);

    logic                   r_active;
    lcfb_pkg::t_lcfb_cmd    r_cmd;
    logic [7:0]             r_sum;
    logic [5:0]             r_idx;
    logic [5:0]             r_last_idx;
    logic                   r_strobe;
    lcfb_pkg::t_lcfb_result r_result;

    logic                   accept;
    logic [7:0]             n_sum;
    logic [7:0]             sum_base;
    logic [15:0]            in_mask;
    logic                   in_grp;
    logic                   in_ctrl;
    logic                   in_mask_used;
    lcfb_pkg::t_lcfb_result mux_out;

    // Ready drops only while bytes other than the closing one remain.
    assign busy   = r_active && (r_idx != r_last_idx);
    assign accept = start && !busy;

    // Checksum of the incoming command: fixed part per layout plus the variable bytes.
    always_comb begin
        in_mask      = lcfb_pkg::group_bits(i_cmd);
        in_grp       = (i_cmd.action == lcfb_pkg::ACT_GRP_SINGLE) ||
                       (i_cmd.action == lcfb_pkg::ACT_GRP_LIST);
        in_ctrl      = (i_cmd.action == lcfb_pkg::ACT_DEV_CTRL) || in_grp ||
                       (i_cmd.action == lcfb_pkg::ACT_DEV_INFO);
        in_mask_used = in_grp || (i_cmd.action == lcfb_pkg::ACT_GRP_SET);
        case (i_cmd.action)
            lcfb_pkg::ACT_DEV_CTRL:   sum_base = lcfb_pkg::SUM_DEV;
            lcfb_pkg::ACT_GRP_SINGLE: sum_base = lcfb_pkg::SUM_GRP;
            lcfb_pkg::ACT_GRP_LIST:   sum_base = lcfb_pkg::SUM_GRP;
            lcfb_pkg::ACT_GRP_SET:    sum_base = lcfb_pkg::SUM_GSET;
            lcfb_pkg::ACT_SENSOR:     sum_base = lcfb_pkg::SUM_SENS;
            lcfb_pkg::ACT_DEV_INFO:   sum_base = lcfb_pkg::SUM_INFO;
            default:                  sum_base = 8'h00;
        endcase
        n_sum = sum_base;
        if (!in_grp) begin
            n_sum = n_sum + i_cmd.device_address[7:0] + i_cmd.device_address[15:8]
                + i_cmd.device_address[23:16] + i_cmd.device_address[31:24];
        end
        if (in_mask_used) begin
            n_sum = n_sum + in_mask[7:0] + in_mask[15:8];
        end
        if (in_ctrl) begin
            n_sum = n_sum + i_cmd.on_off + i_cmd.dimmer[7:0] + i_cmd.dimmer[15:8];
        end
    end

    // Byte selection for the current position of the stored command.
    lcfb_byte_mux u_byte_mux (
        .i_cmd      (r_cmd),
        .i_idx      (r_idx),
        .i_checksum (r_sum),
        .o_result   (mux_out)
    );

    // Command capture and byte sequencing.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_idx    <= 6'd0;
        end else if (accept) begin
            r_active <= lcfb_pkg::action_valid(i_cmd.action);
            r_idx    <= 6'd0;
        end else if (r_active) begin
            if (r_idx == r_last_idx) begin
                r_active <= 1'b0;
            end else begin
                r_idx <= r_idx + 6'd1;
            end
        end
    end

    // Payload of the stored command.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd      <= i_cmd;
            r_sum      <= n_sum;
            r_last_idx <= lcfb_pkg::last_index(i_cmd.action);
        end
    end

    // Output register: one byte item per cycle while a frame is running.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_active;
        end
        if (r_active) begin
            r_result <= mux_out;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

    // A frame in progress always delivers a byte in the next cycle.
    a_busy_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> o_strobe)
        else $error("frame byte missing while busy");

    // The closing byte is the end marker.
    a_last_eof: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.last_byte) |-> (o_result.frame_byte == lcfb_pkg::B_EOF))
        else $error("closing byte is not the end marker");

    // A byte right after a closing byte opens a new frame.
    a_next_sof: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.last_byte) |=>
            (!o_strobe || (o_result.frame_byte == lcfb_pkg::B_SOF && !o_result.last_byte)))
        else $error("frame following a closing byte does not start correctly");

    // A valid command starts a frame whose first byte is the start marker.
    a_accept_sof: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && lcfb_pkg::action_valid(i_cmd.action)) |=> ##1
            (o_strobe && o_result.frame_byte == lcfb_pkg::B_SOF))
        else $error("accepted command did not open a frame");

endmodule

// File: sim/tb_top.sv
// Self-checking testbench for the lighting command frame builder: command driver, byte monitor.
`timescale 1ns / 1ps

module tb_top;

    // Actions that the block accepts but answers with no frame.
    localparam logic [2:0] ACT_RSVD_6 = 3'd6;
    localparam logic [2:0] ACT_RSVD_7 = 3'd7;

    localparam int FRAME_LEN_LONG  = 43;
    localparam int FRAME_LEN_SHORT = 38;
    localparam int RANDOM_CMDS     = 410;
    localparam int DRAIN_CYCLES    = 60;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int PRINT_LIMIT     = 100;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   start = 1'b0;
    lcfb_pkg::t_lcfb_cmd    i_cmd = '0;
    logic                   busy;
    logic                   o_strobe;
    lcfb_pkg::t_lcfb_result o_result;

    // Commands waiting to be sent and frame bytes waiting to arrive.
    lcfb_pkg::t_lcfb_cmd    pending_cmds[$];
    lcfb_pkg::t_lcfb_result frame_q[$];

    int unsigned  err_count = 0;
    int unsigned  cycle_count = 0;
    int unsigned  frame_count = 0;
    int unsigned  byte_idx = 0;

    // Driver pacing state.
    int unsigned            gap_left = 0;
    bit                     gap_idle_only = 1'b0;
    int unsigned            calm_left = 0;
    logic                   drv_start;
    lcfb_pkg::t_lcfb_cmd    drv_cmd;
    lcfb_pkg::t_lcfb_result want;

    lighting_command_frame_builder dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_cmd    (i_cmd),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    // Free-running clock, 4 ns period.
    always #2 i_clk = ~i_clk;

    // One line per mismatch, capped so that a broken block cannot flood the log.
    task automatic report_mismatch(input string msg);
        if (err_count < PRINT_LIMIT) begin
            $display("MISMATCH @%0t: %s", $realtime, msg);
        end
        err_count++;
    endtask

    function automatic lcfb_pkg::t_lcfb_cmd make_cmd(input logic [2:0] act,
                                                     input logic [31:0] addr,
                                                     input logic [4:0] gid,
                                                     input logic [15:0] mask,
                                                     input logic [7:0] onoff,
                                                     input logic [15:0] dim);
        lcfb_pkg::t_lcfb_cmd c;
        c.action         = act;
        c.device_address = addr;
        c.group_id       = gid;
        c.group_mask     = mask;
        c.on_off         = onoff;
        c.dimmer         = dim;
        return c;
    endfunction

    // Build the frame that a command should produce and queue its bytes.
    task automatic predict_frame(input lcfb_pkg::t_lcfb_cmd cmd);
        logic [7:0]             fb [FRAME_LEN_LONG];
        logic [15:0]            grp;
        logic [7:0]             csum;
        int                     flen;
        int                     k;
        lcfb_pkg::t_lcfb_result r;
        if (cmd.action > lcfb_pkg::ACT_DEV_INFO) begin
            return;
        end
        foreach (fb[j]) fb[j] = 8'h00;
        flen = FRAME_LEN_LONG;

        // Single id maps to one bit; ids outside 1..16 give an empty mask.
        grp = '0;
        if (cmd.group_id >= 5'd1 && cmd.group_id <= 5'd16) begin
            grp = 16'd1 << (cmd.group_id - 5'd1);
        end
        if (cmd.action == lcfb_pkg::ACT_GRP_LIST) begin
            grp = cmd.group_mask;
        end

        // Common header and unicast address, low byte first.
        fb[0]  = lcfb_pkg::B_SOF;
        fb[1]  = lcfb_pkg::B_LEN_LONG;
        fb[2]  = lcfb_pkg::B_SYNC0;
        fb[3]  = lcfb_pkg::B_SYNC1;
        {fb[21], fb[20], fb[19], fb[18]} = cmd.device_address;
        fb[28] = lcfb_pkg::B_TYPE_CTRL;

        case (cmd.action)
            lcfb_pkg::ACT_GRP_SINGLE, lcfb_pkg::ACT_GRP_LIST: begin
                for (k = 18; k < 22; k++) fb[k] = lcfb_pkg::B_BCAST;
                fb[29] = lcfb_pkg::B_ONE;
                fb[30] = grp[7:0];
                fb[31] = grp[15:8];
            end
            lcfb_pkg::ACT_GRP_SET: begin
                fb[32] = lcfb_pkg::B_CMD_GSET0;
                fb[33] = lcfb_pkg::B_CMD_GSET1;
                fb[34] = lcfb_pkg::B_GSET_SUB;
                fb[36] = lcfb_pkg::B_CLASS;
                fb[37] = grp[7:0];
                fb[38] = grp[15:8];
            end
            lcfb_pkg::ACT_SENSOR: begin
                flen   = FRAME_LEN_SHORT;
                fb[1]  = lcfb_pkg::B_LEN_SHORT;
                fb[28] = lcfb_pkg::B_TYPE_INFO;
                fb[32] = lcfb_pkg::B_CMD_SENS0;
                fb[33] = lcfb_pkg::B_CMD_SENS1;
            end
            lcfb_pkg::ACT_DEV_INFO: begin
                fb[1]  = lcfb_pkg::B_LEN_SHORT;
                fb[28] = lcfb_pkg::B_TYPE_INFO;
            end
            default: begin
            end
        endcase

        // Control tail with on/off and dimmer for all but group set and sensor query.
        if (cmd.action != lcfb_pkg::ACT_GRP_SET && cmd.action != lcfb_pkg::ACT_SENSOR) begin
            fb[32] = lcfb_pkg::B_CMD_CTRL0;
            fb[33] = lcfb_pkg::B_CMD_CTRL1;
            fb[36] = lcfb_pkg::B_CLASS;
            fb[37] = lcfb_pkg::B_ONE;
            fb[38] = cmd.on_off;
            fb[39] = cmd.dimmer[7:0];
            fb[40] = cmd.dimmer[15:8];
        end

        // Additive checksum over bytes 2 through the one before it.
        csum = 8'h00;
        for (k = 2; k <= flen - 3; k++) csum = csum + fb[k];
        fb[flen - 2] = csum;
        fb[flen - 1] = lcfb_pkg::B_EOF;

        for (k = 0; k < flen; k++) begin
            r.frame_byte = fb[k];
            r.last_byte  = (k == flen - 1);
            frame_q.push_back(r);
        end
    endtask

    // Driver: hands commands to the block and predicts each one it takes.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            drv_start = start;
            drv_cmd   = i_cmd;
            if (start && !busy) begin
                predict_frame(i_cmd);
                drv_start = 1'b0;
                // Wait before the next item; now and then a stretch with no waits.
                if (calm_left != 0) begin
                    calm_left--;
                    gap_left = 0;
                end else begin
                    gap_left      = $urandom_range(0, 6);
                    gap_idle_only = 1'($urandom_range(0, 1));
                    if ($urandom_range(0, 15) == 0) begin
                        calm_left = $urandom_range(4, 16);
                    end
                end
            end
            if (!drv_start) begin
                if (gap_left != 0) begin
                    // Some waits count every cycle, others only cycles the block is free.
                    if (!gap_idle_only || !busy) begin
                        gap_left--;
                    end
                end else if (pending_cmds.size() != 0) begin
                    drv_cmd   = pending_cmds.pop_front();
                    drv_start = 1'b1;
                end
            end
            start <= drv_start;
            i_cmd <= drv_cmd;
        end
    end

    // Monitor: every strobed byte is checked against the oldest predicted byte.
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe !== 1'b0) begin
            if (frame_q.size() == 0) begin
                report_mismatch($sformatf("unexpected byte %02h last=%b",
                                          o_result.frame_byte, o_result.last_byte));
            end else begin
                want = frame_q.pop_front();
                if (o_result.frame_byte !== want.frame_byte) begin
                    report_mismatch($sformatf("frame %0d byte %0d: frame_byte %02h, want %02h",
                                              frame_count, byte_idx, o_result.frame_byte,
                                              want.frame_byte));
                end
                if (o_result.last_byte !== want.last_byte) begin
                    report_mismatch($sformatf("frame %0d byte %0d: last_byte %b, want %b",
                                              frame_count, byte_idx, o_result.last_byte,
                                              want.last_byte));
                end
                if (want.last_byte) begin
                    frame_count++;
                    byte_idx = 0;
                end else begin
                    byte_idx++;
                end
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        lcfb_pkg::t_lcfb_cmd c;
        int unsigned         sel;

        // Directed: every action, field extremes, out-of-range group ids, unused actions.
        pending_cmds.push_back(make_cmd(lcfb_pkg::ACT_DEV_CTRL, 32'h0000_0000, 5'd0, 16'h0000,
                                        8'h00, 16'h0000));
        pending_cmds.push_back(make_cmd(lcfb_pkg::ACT_DEV_CTRL, 32'hFFFF_FFFF, 5'd31, 16'hFFFF,
                                        8'hFF, 16'hFFFF));
        pending_cmds.push_back(make_cmd(lcfb_pkg::ACT_DEV_CTRL, 32'h1234_5678, 5'd5, 16'hA5A5,
                                        8'h01, 16'h00FF));
        pending_cmds.push_back(make_cmd(lcfb_pkg::ACT_GRP_SINGLE, 32'h0000_0000, 5'd1, 16'h0000,
                                        8'h00, 16'h0000));
        pending_cmds.push_back(make_cmd(lcfb_pkg::ACT_GRP_SINGLE, 32'hFFFF_FFFF, 5'd16, 16'hFFFF,
                                        8'hFF, 16'hFFFF));
        pending_cmds.push_back(make_cmd(lcfb_pkg::ACT_GRP_SINGLE, 32'hDEAD_BEEF, 5'd0, 16'h1234,
                                        8'h80, 16'h8000));
        pending_cmds.push_back(make_cmd(lcfb_pkg::ACT_GRP_SINGLE, 32'h0BAD_F00D, 5'd17, 16'h0001,
                                        8'h7F, 16'h7FFF));
        pending_cmds.push_back(make_cmd(lcfb_pkg::ACT_GRP_SINGLE, 32'h0000_0001, 5'd31, 16'h0000,
                                        8'h55, 16'h5555));
        pending_cmds.push_back(make_cmd(lcfb_pkg::ACT_GRP_LIST, 32'h0000_0000, 5'd0, 16'h0000,
                                        8'h00, 16'h0000));
        pending_cmds.push_back(make_cmd(lcfb_pkg::ACT_GRP_LIST, 32'hFFFF_FFFF, 5'd31, 16'hFFFF,
                                        8'hFF, 16'hFFFF));
        pending_cmds.push_back(make_cmd(lcfb_pkg::ACT_GRP_LIST, 32'h5555_AAAA, 5'd9, 16'h8001,
                                        8'hAA, 16'hAAAA));
        pending_cmds.push_back(make_cmd(lcfb_pkg::ACT_GRP_SET, 32'h0000_0000, 5'd1, 16'h0000,
                                        8'h00, 16'h0000));
        pending_cmds.push_back(make_cmd(lcfb_pkg::ACT_GRP_SET, 32'hFFFF_FFFF, 5'd16, 16'hFFFF,
                                        8'hFF, 16'hFFFF));
        pending_cmds.push_back(make_cmd(lcfb_pkg::ACT_GRP_SET, 32'h8765_4321, 5'd0, 16'h00F0,
                                        8'h12, 16'h3456));
        pending_cmds.push_back(make_cmd(lcfb_pkg::ACT_GRP_SET, 32'hCAFE_0001, 5'd20, 16'h0F00,
                                        8'h34, 16'h789A));
        pending_cmds.push_back(make_cmd(lcfb_pkg::ACT_GRP_SET, 32'h0000_FFFF, 5'd8, 16'h0000,
                                        8'h00, 16'h0000));
        pending_cmds.push_back(make_cmd(lcfb_pkg::ACT_SENSOR, 32'h0000_0000, 5'd0, 16'h0000,
                                        8'h00, 16'h0000));
        pending_cmds.push_back(make_cmd(lcfb_pkg::ACT_SENSOR, 32'hFFFF_FFFF, 5'd31, 16'hFFFF,
                                        8'hFF, 16'hFFFF));
        pending_cmds.push_back(make_cmd(lcfb_pkg::ACT_DEV_INFO, 32'h0000_0000, 5'd0, 16'h0000,
                                        8'h00, 16'h0000));
        pending_cmds.push_back(make_cmd(lcfb_pkg::ACT_DEV_INFO, 32'hFFFF_FFFF, 5'd31, 16'hFFFF,
                                        8'hFF, 16'hFFFF));
        pending_cmds.push_back(make_cmd(ACT_RSVD_6, 32'hFFFF_FFFF, 5'd3, 16'hFFFF,
                                        8'hFF, 16'hFFFF));
        pending_cmds.push_back(make_cmd(ACT_RSVD_7, 32'h0000_0000, 5'd0, 16'h0000,
                                        8'h00, 16'h0000));
        pending_cmds.push_back(make_cmd(lcfb_pkg::ACT_SENSOR, 32'h2468_ACE0, 5'd4, 16'h0000,
                                        8'h99, 16'h1111));

        // Random commands, mostly valid actions with in-range group ids.
        for (int n = 0; n < RANDOM_CMDS; n++) begin
            sel = $urandom_range(0, 19);
            if (sel == 19) begin
                c.action = $urandom_range(0, 1) ? ACT_RSVD_7 : ACT_RSVD_6;
            end else begin
                c.action = 3'(sel % 6);
            end
            c.device_address = $urandom();
            if ($urandom_range(0, 7) == 0) begin
                c.group_id = 5'($urandom_range(0, 31));
            end else begin
                c.group_id = 5'($urandom_range(1, 16));
            end
            case ($urandom_range(0, 5))
                0:       c.group_mask = 16'h0000;
                1:       c.group_mask = 16'hFFFF;
                2:       c.group_mask = 16'd1 << $urandom_range(0, 15);
                default: c.group_mask = 16'($urandom_range(0, 16'hFFFF));
            endcase
            c.on_off = 8'($urandom_range(0, 255));
            c.dimmer = 16'($urandom_range(0, 16'hFFFF));
            pending_cmds.push_back(c);
        end

        // Reset held low once, at the start of the run.
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait until every command is taken and every byte has come back.
        do begin
            @(negedge i_clk);
        end while (pending_cmds.size() != 0 || start || frame_q.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (err_count == 0 && frame_q.size() == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/core/lcfb_pkg.sv
rtl/core/lcfb_byte_mux.sv
rtl/core/lighting_command_frame_builder.sv
sim/tb_top.sv
